// File: hw/rtl/cfa_pkg.sv
`timescale 1ns / 1ps

package cfa_pkg;

  localparam int FRAMES     = 256;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int CNT_W      = $clog2(FRAMES + 1);

  localparam int PID_W      = 8;
  localparam int OWNER_W    = PID_W + 1;
  localparam int SIZE_W     = 11;
  localparam int NEED_W     = SIZE_W - 1;
  localparam int COUNT_W    = 9;
  localparam int TOTAL_W    = 9;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 16;
  localparam int START_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

  localparam logic [OWNER_W-1:0] FREE_MARK   = {1'b1, {PID_W{1'b0}}};
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 9'd256;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 1'd1;

  localparam logic [STATUS_W-1:0] STATUS_ALLOC = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INSUF = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd3;

  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_addr;
    logic [OWNER_W-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic              clr;
    logic              step;
    logic              is_free;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  need;
    logic [MODE_W-1:0] mode;
  } trk_ctl_t;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] start;
  } trk_res_t;

  function automatic logic [CNT_W-1:0] eff_frames(input logic [TOTAL_W-1:0] total);
    logic [CNT_W-1:0] r;
    if (int'(total) > FRAMES) begin
      r = CNT_W'(FRAMES);
    end else begin
      r = CNT_W'(total);
    end
    return r;
  endfunction

  function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                 input logic [STAT_W-1:0] b);
    logic [STAT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/cfa_ifs.sv
`timescale 1ns / 1ps

interface cfa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [cfa_pkg::PID_W-1:0]  process_id;
  logic [cfa_pkg::SIZE_W-1:0] size_kb;
  modport source (output valid, output kind, output process_id, output size_kb,
                  input ready);
  modport sink (input valid, input kind, input process_id, input size_kb,
                output ready);
endinterface

interface cfa_out_if;
  logic                         valid;
  logic                         ready;
  logic [cfa_pkg::STATUS_W-1:0] status;
  logic [cfa_pkg::START_W-1:0]  start_frame;
  logic [cfa_pkg::COUNT_W-1:0]  frame_count;
  logic [cfa_pkg::CNT_W-1:0]    free_frames;
  logic [cfa_pkg::STAT_W-1:0]   internal_waste_kb;
  logic [cfa_pkg::STAT_W-1:0]   external_rejects;
  logic [cfa_pkg::STAT_W-1:0]   insufficient_rejects;
  modport source (output valid, output status, output start_frame, output frame_count,
                  output free_frames, output internal_waste_kb, output external_rejects,
                  output insufficient_rejects, input ready);
  modport sink (input valid, input status, input start_frame, input frame_count,
                input free_frames, input internal_waste_kb, input external_rejects,
                input insufficient_rejects, output ready);
endinterface

interface cfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfa_pkg::CFG_IDX_W-1:0]  idx;
  logic [cfa_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

// File: hw/rtl/cfa_frame_ram.sv
`timescale 1ns / 1ps

module cfa_frame_ram (
  input  logic                          clk,
  input  cfa_pkg::ram_req_t             req,
  output logic [cfa_pkg::OWNER_W-1:0]   rd_data
);

  logic [cfa_pkg::OWNER_W-1:0] mem [cfa_pkg::FRAMES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: hw/rtl/cfa_hole_track.sv
`timescale 1ns / 1ps

module cfa_hole_track (
  input  logic              clk,
  input  logic              rst_n,
  input  cfa_pkg::trk_ctl_t ctl,
  output cfa_pkg::trk_res_t res
);

  logic [cfa_pkg::FRAME_W-1:0] run_start_r, run_start_nxt;
  logic [cfa_pkg::CNT_W-1:0]   run_len_r, run_len_nxt;
  logic [cfa_pkg::CNT_W-1:0]   best_len_r, best_len_nxt;
  logic                        found_r, found_nxt;
  logic [cfa_pkg::FRAME_W-1:0] start_r, start_nxt;
  logic                        take;

  always_comb begin
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    best_len_nxt  = best_len_r;
    found_nxt     = found_r;
    start_nxt     = start_r;
    take          = 1'b0;
    if (ctl.clr) begin
      run_len_nxt  = '0;
      best_len_nxt = '0;
      found_nxt    = 1'b0;
    end else if (ctl.step) begin
      if (ctl.is_free) begin
        if (run_len_r == '0) begin
          run_start_nxt = ctl.pos[cfa_pkg::FRAME_W-1:0];
        end
        run_len_nxt = run_len_r + 1'b1;
      end else begin
        if (run_len_r >= ctl.need && run_len_r != '0) begin
          if (!found_r) begin
            take = 1'b1;
          end else if (ctl.mode == cfa_pkg::FIT_BEST) begin
            take = run_len_r < best_len_r;
          end else if (ctl.mode == cfa_pkg::FIT_WORST) begin
            take = run_len_r > best_len_r;
          end
        end
        if (take) begin
          found_nxt    = 1'b1;
          start_nxt    = run_start_r;
          best_len_nxt = run_len_r;
        end
        run_len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r  <= '0;
      best_len_r <= '0;
      found_r    <= 1'b0;
    end else begin
      run_len_r  <= run_len_nxt;
      best_len_r <= best_len_nxt;
      found_r    <= found_nxt;
    end
    run_start_r <= run_start_nxt;
    start_r     <= start_nxt;
  end

  assign res.found = found_r;
  assign res.start = start_r;

endmodule

// File: hw/rtl/cfa_ctrl.sv
`timescale 1ns / 1ps

module cfa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  cfa_in_if.sink                      in_ch,
  cfa_out_if.source                   out_ch,
  cfa_cfg_if.sink                     cfg_ch,
  output cfa_pkg::ram_req_t           ram_req,
  input  logic [cfa_pkg::OWNER_W-1:0] ram_rd_data,
  output cfa_pkg::trk_ctl_t           trk_ctl,
  input  cfa_pkg::trk_res_t           trk_res
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FREE_SCAN, S_HOLE_SCAN, S_HOLE_END, S_FILL, S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [cfa_pkg::MODE_W-1:0]   fit_mode_r, fit_mode_nxt;
  logic [cfa_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [cfa_pkg::CNT_W-1:0]    free_count_r, free_count_nxt;
  logic [cfa_pkg::STAT_W-1:0]   waste_r, waste_nxt;
  logic [cfa_pkg::STAT_W-1:0]   ext_r, ext_nxt;
  logic [cfa_pkg::STAT_W-1:0]   ins_r, ins_nxt;
  logic [cfa_pkg::PID_W-1:0]    pid_r, pid_nxt;
  logic [cfa_pkg::SIZE_W-1:0]   size_r, size_nxt;
  logic [cfa_pkg::NEED_W-1:0]   need_r, need_nxt;
  logic [cfa_pkg::CNT_W-1:0]    pos_r, pos_nxt;
  logic                         issue_done_r, issue_done_nxt;
  logic                         s_vld_r, s_vld_nxt;
  logic [cfa_pkg::CNT_W-1:0]    s_pos_r, s_pos_nxt;
  logic                         s_last_r, s_last_nxt;
  logic [cfa_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [cfa_pkg::FRAME_W-1:0]  fill_pos_r, fill_pos_nxt;
  logic [cfa_pkg::CNT_W-1:0]    fill_left_r, fill_left_nxt;
  logic [cfa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [cfa_pkg::START_W-1:0]  res_start_r, res_start_nxt;
  logic [cfa_pkg::COUNT_W-1:0]  res_count_r, res_count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [cfa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [cfa_pkg::START_W-1:0]  out_start_r, out_start_nxt;
  logic [cfa_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [cfa_pkg::CNT_W-1:0]    out_free_r, out_free_nxt;
  logic [cfa_pkg::STAT_W-1:0]   out_waste_r, out_waste_nxt;
  logic [cfa_pkg::STAT_W-1:0]   out_ext_r, out_ext_nxt;
  logic [cfa_pkg::STAT_W-1:0]   out_ins_r, out_ins_nxt;

  logic [cfa_pkg::CNT_W-1:0]    n_frames;
  logic [cfa_pkg::SIZE_W:0]     size_p3;
  logic [cfa_pkg::NEED_W-1:0]   need_in;
  logic [cfa_pkg::COUNT_W-1:0]  count_in;
  logic [cfa_pkg::STAT_W-1:0]   waste_add;

  assign n_frames = cfa_pkg::eff_frames(total_r);
  assign size_p3  = {1'b0, in_ch.size_kb} + (cfa_pkg::SIZE_W+1)'(3);
  assign need_in  = size_p3[cfa_pkg::SIZE_W:2];
  assign count_in = (int'(need_in) > cfa_pkg::COUNT_MAX) ?
                    cfa_pkg::COUNT_W'(cfa_pkg::COUNT_MAX) : cfa_pkg::COUNT_W'(need_in);
  assign waste_add = cfa_pkg::STAT_W'(3'd4 - {1'b0, size_r[1:0]});

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    fit_mode_nxt   = fit_mode_r;
    total_nxt      = total_r;
    free_count_nxt = free_count_r;
    waste_nxt      = waste_r;
    ext_nxt        = ext_r;
    ins_nxt        = ins_r;
    pid_nxt        = pid_r;
    size_nxt       = size_r;
    need_nxt       = need_r;
    pos_nxt        = pos_r;
    issue_done_nxt = issue_done_r;
    s_vld_nxt      = 1'b0;
    s_pos_nxt      = s_pos_r;
    s_last_nxt     = s_last_r;
    cnt_nxt        = cnt_r;
    fill_pos_nxt   = fill_pos_r;
    fill_left_nxt  = fill_left_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_count_nxt  = out_count_r;
    out_free_nxt   = out_free_r;
    out_waste_nxt  = out_waste_r;
    out_ext_nxt    = out_ext_r;
    out_ins_nxt    = out_ins_r;

    ram_req         = '0;
    trk_ctl         = '0;
    trk_ctl.clr     = (state_r == S_IDLE);
    trk_ctl.pos     = s_pos_r;
    trk_ctl.need    = cfa_pkg::CNT_W'(need_r);
    trk_ctl.mode    = fit_mode_r;
    trk_ctl.is_free = !s_last_r && (ram_rd_data == cfa_pkg::FREE_MARK);

    if ((state_r == S_FREE_SCAN || state_r == S_HOLE_SCAN) && !issue_done_r) begin
      ram_req.rd_en  = 1'b1;
      ram_req.rd_addr = pos_r[cfa_pkg::FRAME_W-1:0];
      s_vld_nxt      = 1'b1;
      s_pos_nxt      = pos_r;
      s_last_nxt     = (pos_r == n_frames);
      pos_nxt        = pos_r + 1'b1;
      issue_done_nxt = (pos_r == n_frames);
    end

    case (state_r)
      S_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = pos_r[cfa_pkg::FRAME_W-1:0];
        ram_req.wr_data = cfa_pkg::FREE_MARK;
        pos_nxt         = pos_r + 1'b1;
        if (pos_r == cfa_pkg::CNT_W'(cfa_pkg::FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        pos_nxt        = '0;
        issue_done_nxt = 1'b0;
        cnt_nxt        = '0;
        if (in_ch.valid) begin
          pid_nxt       = in_ch.process_id;
          size_nxt      = in_ch.size_kb;
          need_nxt      = need_in;
          res_start_nxt = '0;
          res_count_nxt = count_in;
          if (in_ch.kind == cfa_pkg::KIND_FREE) begin
            state_nxt = S_FREE_SCAN;
          end else if (int'(need_in) > int'(free_count_r)) begin
            res_status_nxt = cfa_pkg::STATUS_INSUF;
            ins_nxt        = cfa_pkg::sat_add(ins_r, cfa_pkg::STAT_W'(1));
            state_nxt      = S_DONE;
          end else if (need_in == '0) begin
            res_status_nxt = cfa_pkg::STATUS_ALLOC;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_HOLE_SCAN;
          end
        end
      end
      S_FREE_SCAN: begin
        if (s_vld_r) begin
          if (s_last_r) begin
            free_count_nxt = free_count_r + cnt_r;
            res_status_nxt = cfa_pkg::STATUS_FREED;
            res_count_nxt  = cfa_pkg::COUNT_W'(cnt_r);
            state_nxt      = S_DONE;
          end else if (ram_rd_data == {1'b0, pid_r}) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = s_pos_r[cfa_pkg::FRAME_W-1:0];
            ram_req.wr_data = cfa_pkg::FREE_MARK;
            cnt_nxt         = cnt_r + 1'b1;
          end
        end
      end
      S_HOLE_SCAN: begin
        trk_ctl.step = s_vld_r;
        if (s_vld_r && s_last_r) begin
          state_nxt = S_HOLE_END;
        end
      end
      S_HOLE_END: begin
        if (trk_res.found) begin
          fill_pos_nxt   = trk_res.start;
          fill_left_nxt  = cfa_pkg::CNT_W'(need_r);
          free_count_nxt = free_count_r - cfa_pkg::CNT_W'(need_r);
          if (size_r[1:0] != 2'd0) begin
            waste_nxt = cfa_pkg::sat_add(waste_r, waste_add);
          end
          res_status_nxt = cfa_pkg::STATUS_ALLOC;
          res_start_nxt  = cfa_pkg::START_W'(trk_res.start);
          state_nxt      = S_FILL;
        end else begin
          ext_nxt        = cfa_pkg::sat_add(ext_r, cfa_pkg::STAT_W'(1));
          res_status_nxt = cfa_pkg::STATUS_EXT;
          state_nxt      = S_DONE;
        end
      end
      S_FILL: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = fill_pos_r;
        ram_req.wr_data = {1'b0, pid_r};
        fill_pos_nxt    = fill_pos_r + 1'b1;
        fill_left_nxt   = fill_left_r - 1'b1;
        if (fill_left_r == cfa_pkg::CNT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          out_count_nxt  = res_count_r;
          out_free_nxt   = free_count_r;
          out_waste_nxt  = waste_r;
          out_ext_nxt    = ext_r;
          out_ins_nxt    = ins_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        cfa_pkg::REG_FIT_MODE: begin
          fit_mode_nxt = cfg_ch.data[cfa_pkg::MODE_W-1:0];
        end
        cfa_pkg::REG_TOTAL_FRAMES: begin
          total_nxt      = cfg_ch.data[cfa_pkg::TOTAL_W-1:0];
          free_count_nxt = cfa_pkg::eff_frames(cfg_ch.data[cfa_pkg::TOTAL_W-1:0]);
          pos_nxt        = '0;
          state_nxt      = S_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      fit_mode_r   <= cfa_pkg::FIT_FIRST;
      total_r      <= cfa_pkg::TOTAL_RESET;
      free_count_r <= cfa_pkg::eff_frames(cfa_pkg::TOTAL_RESET);
      waste_r      <= '0;
      ext_r        <= '0;
      ins_r        <= '0;
      pos_r        <= '0;
      issue_done_r <= 1'b0;
      s_vld_r      <= 1'b0;
      cnt_r        <= '0;
      fill_left_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fit_mode_r   <= fit_mode_nxt;
      total_r      <= total_nxt;
      free_count_r <= free_count_nxt;
      waste_r      <= waste_nxt;
      ext_r        <= ext_nxt;
      ins_r        <= ins_nxt;
      pos_r        <= pos_nxt;
      issue_done_r <= issue_done_nxt;
      s_vld_r      <= s_vld_nxt;
      cnt_r        <= cnt_nxt;
      fill_left_r  <= fill_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pid_r        <= pid_nxt;
    size_r       <= size_nxt;
    need_r       <= need_nxt;
    s_pos_r      <= s_pos_nxt;
    s_last_r     <= s_last_nxt;
    fill_pos_r   <= fill_pos_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_count_r  <= out_count_nxt;
    out_free_r   <= out_free_nxt;
    out_waste_r  <= out_waste_nxt;
    out_ext_r    <= out_ext_nxt;
    out_ins_r    <= out_ins_nxt;
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.status               = out_status_r;
  assign out_ch.start_frame          = out_start_r;
  assign out_ch.frame_count          = out_count_r;
  assign out_ch.free_frames          = out_free_r;
  assign out_ch.internal_waste_kb    = out_waste_r;
  assign out_ch.external_rejects     = out_ext_r;
  assign out_ch.insufficient_rejects = out_ins_r;

endmodule

// File: hw/rtl/contiguous_frame_allocator.sv
// Channel  Role    Payload
// in_ch    sink    kind, process_id, size_kb
// out_ch   source  status, start_frame, frame_count, free_frames, three running totals
// cfg_ch   sink    idx (0 fit_mode, 1 total_frames), data
//
// A free scans the table and releases the frames of its process; an allocation scans for
// a hole (S_HOLE_SCAN, S_HOLE_END), then fills it (S_FILL) or is rejected for
// fragmentation. Scans read the table one entry per cycle up to the effective frame count.
// Requests rejected for insufficient memory or of zero size skip the scan. After reset
// and after each write of total_frames a clearing pass marks all 256 frames free, during
// which no input transaction is accepted; configuration writes are always taken. A new
// input transaction is accepted while the previous result waits on out_ch.
`timescale 1ns / 1ps

module contiguous_frame_allocator (
  input  logic      clk,
  input  logic      rst_n,
  cfa_in_if.sink    in_ch,
  cfa_out_if.source out_ch,
  cfa_cfg_if.sink   cfg_ch
);

  cfa_pkg::ram_req_t           ram_req;
  logic [cfa_pkg::OWNER_W-1:0] ram_rd_data;
  cfa_pkg::trk_ctl_t           trk_ctl;
  cfa_pkg::trk_res_t           trk_res;

  cfa_frame_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  cfa_hole_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (trk_ctl),
    .res   (trk_res)
  );

  cfa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .trk_ctl     (trk_ctl),
    .trk_res     (trk_res)
  );

endmodule
